// ===== hw/rtl/usb_power_cycle_sequencer_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the power-cycle sequencer.
// ---------------------------------------------------------------------------
`ifndef USB_POWER_CYCLE_SEQUENCER_TOP_MACROS_SVH
`define USB_POWER_CYCLE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/usb_pcs_pkg.sv =====
// ---------------------------------------------------------------------------
// usb_pcs_pkg
// Types, codes and constants of the USB power-cycle sequencer.
// ---------------------------------------------------------------------------
package usb_pcs_pkg;

	// Default width of the millisecond wait counter.
	localparam int TIMER_BITS_DEF = 16;

	// Dead time limits and register reset values, in milliseconds.
	localparam logic [15:0] DEAD_MIN        = 16'd250;
	localparam logic [15:0] DEAD_MAX        = 16'd30000;
	localparam logic [15:0] DEAD_DEF_RESET  = 16'd4000;
	localparam logic [9:0]  STAGGER_RESET   = 10'd50;

	// Command codes.
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_PLUG  = 3'd1;
	localparam logic [2:0] CMD_CYCLE = 3'd2;
	localparam logic [2:0] CMD_BATT  = 3'd3;
	localparam logic [2:0] CMD_DATA  = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_DISABLED = 2'd1;
	localparam logic [1:0] ST_BUSY     = 2'd2;
	localparam logic [1:0] ST_TICK     = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_DEAD    = 2'd1;
	localparam logic [1:0] REG_STAGGER = 2'd2;
	localparam logic [1:0] REG_INVERT  = 2'd3;

	// Sequence phases.
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_PLUG_WAIT = 4'd1,
		PH_CYC_DOWN  = 4'd2,
		PH_CYC_DEAD  = 4'd3,
		PH_CYC_UP    = 4'd4
	} phase_t;

	// Configuration register contents.
	typedef struct packed {
		logic        enable;
		logic [15:0] default_dead_ms;
		logic [9:0]  stagger_ms;
		logic        mux_invert;
	} cfg_t;

	// Sequence state apart from the wait counter.
	typedef struct packed {
		phase_t      phase;
		logic [15:0] dead_time;
		logic        plug_dir;
		logic        usb_rail;
		logic        battery;
		logic        data;
	} seq_state_t;

	// One result beat.
	typedef struct packed {
		logic [1:0] status;
		logic       busy;
		logic       usb_on;
		logic       batt_on;
		logic       data_on;
		logic       usb_lvl;
		logic       batt_lvl;
		logic       mux_lvl;
	} result_t;

endpackage

// ===== hw/rtl/usb_pcs_cfg.sv =====
// ---------------------------------------------------------------------------
// usb_pcs_cfg
// Configuration register file, written one beat per cycle.
// ---------------------------------------------------------------------------
module usb_pcs_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output usb_pcs_pkg::cfg_t   cfg
);

	usb_pcs_pkg::cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file with reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b0;
			cfg_q.default_dead_ms <= usb_pcs_pkg::DEAD_DEF_RESET;
			cfg_q.stagger_ms      <= usb_pcs_pkg::STAGGER_RESET;
			cfg_q.mux_invert      <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				usb_pcs_pkg::REG_ENABLE:  cfg_q.enable          <= cfg_data[0];
				usb_pcs_pkg::REG_DEAD:    cfg_q.default_dead_ms <= cfg_data;
				usb_pcs_pkg::REG_STAGGER: cfg_q.stagger_ms      <= cfg_data[9:0];
				usb_pcs_pkg::REG_INVERT:  cfg_q.mux_invert      <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/usb_pcs_step.sv =====
// ---------------------------------------------------------------------------
// usb_pcs_step
// Next-state and result logic for one command beat.
// ---------------------------------------------------------------------------
module usb_pcs_step #(
	parameter int TIMER_BITS = usb_pcs_pkg::TIMER_BITS_DEF
) (
	input  usb_pcs_pkg::cfg_t        cfg,
	input  logic [2:0]               command,
	input  logic [15:0]              value,
	input  usb_pcs_pkg::seq_state_t  cur,
	input  logic [TIMER_BITS-1:0]    wait_cur,
	output usb_pcs_pkg::seq_state_t  nxt,
	output logic [TIMER_BITS-1:0]    wait_nxt,
	output usb_pcs_pkg::result_t     res
);

	localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

	logic [TIMER_BITS-1:0] stagger_t;
	logic [TIMER_BITS-1:0] dead_t;
	logic [TIMER_BITS-1:0] wait_dec;
	logic [15:0]           dead_req;
	logic [1:0]            status;
	logic                  val_nz;

	// Delays saturated to the counter width.
	assign stagger_t = ({23'd0, cfg.stagger_ms} > TMAX) ? TMAX[TIMER_BITS-1:0]
		: TIMER_BITS'({23'd0, cfg.stagger_ms});
	assign dead_t = ({17'd0, cur.dead_time} > TMAX) ? TMAX[TIMER_BITS-1:0]
		: TIMER_BITS'({17'd0, cur.dead_time});

	assign wait_dec = (wait_cur != '0) ? wait_cur - TIMER_BITS'(1) : wait_cur;
	assign val_nz   = (value != 16'd0);

	// Requested dead time, defaulted or clamped.
	always_comb begin
		if (value <= 16'd1) begin
			dead_req = cfg.default_dead_ms;
		end else if (value < usb_pcs_pkg::DEAD_MIN) begin
			dead_req = usb_pcs_pkg::DEAD_MIN;
		end else if (value > usb_pcs_pkg::DEAD_MAX) begin
			dead_req = usb_pcs_pkg::DEAD_MAX;
		end else begin
			dead_req = value;
		end
	end

	// Command decode and sequence stepping.
	always_comb begin
		nxt      = cur;
		wait_nxt = wait_cur;
		status   = usb_pcs_pkg::ST_TICK;
		case (command)
			usb_pcs_pkg::CMD_TICK: begin
				if (cur.phase != usb_pcs_pkg::PH_IDLE) begin
					wait_nxt = wait_dec;
					if (wait_dec == '0) begin
						case (cur.phase)
							usb_pcs_pkg::PH_PLUG_WAIT: begin
								if (cur.plug_dir) begin
									nxt.data = 1'b1;
								end else begin
									nxt.usb_rail = 1'b0;
								end
								nxt.phase = usb_pcs_pkg::PH_IDLE;
							end
							usb_pcs_pkg::PH_CYC_DOWN: begin
								nxt.usb_rail = 1'b0;
								nxt.battery  = 1'b0;
								wait_nxt     = dead_t;
								nxt.phase    = usb_pcs_pkg::PH_CYC_DEAD;
							end
							usb_pcs_pkg::PH_CYC_DEAD: begin
								nxt.usb_rail = 1'b1;
								nxt.battery  = 1'b1;
								wait_nxt     = stagger_t;
								nxt.phase    = usb_pcs_pkg::PH_CYC_UP;
							end
							usb_pcs_pkg::PH_CYC_UP: begin
								nxt.data  = 1'b1;
								nxt.phase = usb_pcs_pkg::PH_IDLE;
							end
							default: begin
								nxt.phase = usb_pcs_pkg::PH_IDLE;
							end
						endcase
					end
				end
			end
			usb_pcs_pkg::CMD_PLUG, usb_pcs_pkg::CMD_CYCLE: begin
				if (!cfg.enable) begin
					status = usb_pcs_pkg::ST_DISABLED;
				end else if (cur.phase != usb_pcs_pkg::PH_IDLE) begin
					status = usb_pcs_pkg::ST_BUSY;
				end else begin
					status   = usb_pcs_pkg::ST_ACCEPTED;
					wait_nxt = stagger_t;
					if (command == usb_pcs_pkg::CMD_PLUG) begin
						nxt.plug_dir = val_nz;
						if (val_nz) begin
							nxt.usb_rail = 1'b1;
						end else begin
							nxt.data = 1'b0;
						end
						nxt.phase = usb_pcs_pkg::PH_PLUG_WAIT;
					end else begin
						nxt.dead_time = dead_req;
						nxt.data      = 1'b0;
						nxt.phase     = usb_pcs_pkg::PH_CYC_DOWN;
					end
				end
			end
			usb_pcs_pkg::CMD_BATT: begin
				nxt.battery = val_nz;
				status      = usb_pcs_pkg::ST_ACCEPTED;
			end
			usb_pcs_pkg::CMD_DATA: begin
				nxt.data = val_nz;
				status   = usb_pcs_pkg::ST_ACCEPTED;
			end
			default: ;
		endcase
	end

	// Result fields from the updated state; relay pins are low when connected.
	always_comb begin
		res.status   = status;
		res.busy     = (nxt.phase != usb_pcs_pkg::PH_IDLE);
		res.usb_on   = nxt.usb_rail;
		res.batt_on  = nxt.battery;
		res.data_on  = nxt.data;
		res.usb_lvl  = ~nxt.usb_rail;
		res.batt_lvl = ~nxt.battery;
		res.mux_lvl  = ~(nxt.data ^ cfg.mux_invert);
	end

endmodule

// ===== hw/rtl/usb_power_cycle_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// usb_power_cycle_sequencer_top
// Sequencer for the USB data mux, USB power relay and battery relay.
// ---------------------------------------------------------------------------
// Usage:
// Command beats (command, value) enter on in_valid/in_ready. A tick command
// advances the sequence timers by one millisecond; the other commands start
// plug or power-cycle sequences or set a switch directly.
// Every command beat yields exactly one result beat on out_valid/out_ready,
// carrying the status, the busy flag, the switch states and the pin levels.
// A beat passes through the input register and then the result
// register. Throughput is one beat per cycle while the receiver takes
// results, set by the combinational state update between the two registers.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data
// and are always taken; write them only while the block is idle.
// Reset disables the block, restores register defaults and leaves all three
// switches connected with no sequence running.
// When the receiver stalls, the result register holds its beat and the input
// register fills; in_ready then drops until the result is taken.
// ---------------------------------------------------------------------------
module usb_power_cycle_sequencer_top #(
	parameter int TIMER_BITS = usb_pcs_pkg::TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        busy_res,
	output logic        usb_power_on,
	output logic        batt_power_on,
	output logic        usb_data_on,
	output logic        usb_relay_level,
	output logic        batt_relay_level,
	output logic        mux_select_level
);

	usb_pcs_pkg::cfg_t        cfg;
	usb_pcs_pkg::seq_state_t  state_q;
	usb_pcs_pkg::seq_state_t  state_nxt;
	usb_pcs_pkg::result_t     res_nxt;
	usb_pcs_pkg::result_t     res_s2;
	logic [TIMER_BITS-1:0]    wait_q;
	logic [TIMER_BITS-1:0]    wait_nxt;
	logic                     valid_s1;
	logic [2:0]               command_s1;
	logic [15:0]              value_s1;
	logic                     valid_s2;
	logic                     step_go;

	// Configuration registers.
	usb_pcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Pipeline handshake: the held beat moves on whenever the result register frees.
	assign step_go  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || step_go;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			value_s1   <= value;
		end
	end

	// Step logic.
	usb_pcs_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.cfg      (cfg),
		.command  (command_s1),
		.value    (value_s1),
		.cur      (state_q),
		.wait_cur (wait_q),
		.nxt      (state_nxt),
		.wait_nxt (wait_nxt),
		.res      (res_nxt)
	);

	// Sequence state, updated once per stepped beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= usb_pcs_pkg::PH_IDLE;
			state_q.dead_time <= 16'd0;
			state_q.plug_dir  <= 1'b0;
			state_q.usb_rail  <= 1'b1;
			state_q.battery   <= 1'b1;
			state_q.data      <= 1'b1;
			wait_q            <= '0;
		end else if (step_go) begin
			state_q <= state_nxt;
			wait_q  <= wait_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_go) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			res_s2 <= res_nxt;
		end
	end

	// Output ports.
	assign out_valid        = valid_s2;
	assign status           = res_s2.status;
	assign busy_res         = res_s2.busy;
	assign usb_power_on     = res_s2.usb_on;
	assign batt_power_on    = res_s2.batt_on;
	assign usb_data_on      = res_s2.data_on;
	assign usb_relay_level  = res_s2.usb_lvl;
	assign batt_relay_level = res_s2.batt_lvl;
	assign mux_select_level = res_s2.mux_lvl;

endmodule

// ===== hw/rtl/usb_pcs_checker.sv =====
// ---------------------------------------------------------------------------
// usb_pcs_checker
// Port-level checks of the sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "usb_power_cycle_sequencer_top_macros.svh"

module usb_pcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic       busy_res,
	input logic       usb_power_on,
	input logic       batt_power_on,
	input logic       usb_relay_level,
	input logic       batt_relay_level
);

	// Relay lines are the inverse of the rail states.
	`PCS_ASSERT_NOW(a_usb_level, clk, arst_n, out_valid, usb_relay_level == !usb_power_on, "usb relay level disagrees with rail state")
	`PCS_ASSERT_NOW(a_batt_level, clk, arst_n, out_valid, batt_relay_level == !batt_power_on, "battery relay level disagrees with rail state")

	// A request refused as busy leaves the running sequence in place.
	`PCS_ASSERT_NOW(a_busy_refusal, clk, arst_n, out_valid && (status == usb_pcs_pkg::ST_BUSY), busy_res, "busy refusal reported while idle")

	// A stalled result beat holds.
	`PCS_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(busy_res), "result beat changed under stall")

endmodule

bind usb_power_cycle_sequencer_top usb_pcs_checker u_pcs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.busy_res         (busy_res),
	.usb_power_on     (usb_power_on),
	.batt_power_on    (batt_power_on),
	.usb_relay_level  (usb_relay_level),
	.batt_relay_level (batt_relay_level)
);
